### sv/nvop_pkg.sv
// Shared types and constants of the name=value option parser.
`default_nettype none

package nvop_pkg;

  // Default width of the byte position counter.
  localparam int unsigned OffsetBitsDefault = 16;

  // Depth of the event queue between the parser and the result stage.
  localparam int unsigned QueueDepth = 4;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 2;

  // Register reset values.
  localparam logic [7:0] MaxNameReset  = 8'd31;
  localparam logic [7:0] MaxValueReset = 8'd63;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegMaxName  = 2'd0,
    RegMaxValue = 2'd1
  } cfg_reg_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KindNameChar  = 3'd0,
    KindValueChar = 3'd1,
    KindPairDone  = 3'd2,
    KindEnd       = 3'd3,
    KindError     = 3'd4
  } kind_e;

  // Error codes.
  typedef enum logic [2:0] {
    ErrNone        = 3'd0,
    ErrNameLong    = 3'd1,
    ErrMissingName = 3'd2,
    ErrBlankBefore = 3'd3,
    ErrEqExpected  = 3'd4,
    ErrSpaceAfter  = 3'd5,
    ErrValueLong   = 3'd6,
    ErrEmptyValue  = 3'd7
  } err_e;

  // Character constants.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEq    = 8'h3D;

  // One parser event: a result, or a pair-complete result followed by an
  // end result when the ending byte closes a value.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_char;
    err_e        err;
    logic [15:0] name_start;
    logic [7:0]  name_len;
    logic [7:0]  value_len;
    logic        dbl;
    logic [15:0] end_start;
  } evt_t;

endpackage

`default_nettype wire

### sv/nvop_front.sv
// Parser front end: accepts bytes, runs the phase machine and emits events.
`default_nettype none

module nvop_front import nvop_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         ch_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  output evt_t                    evt_o,
  output logic                    evt_push_o
);

  typedef enum logic [5:0] {
    PhSkip   = 6'b000001,
    PhName   = 6'b000010,
    PhBlank  = 6'b000100,
    PhVFirst = 6'b001000,
    PhValue  = 6'b010000,
    PhIgnore = 6'b100000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [7:0]             name_cnt_q, name_cnt_d;
  logic [7:0]             value_cnt_q, value_cnt_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] pair_start_q, pair_start_d;
  logic [7:0]             max_name_q, max_value_q;

  logic  blank, wide_space;
  err_e  err;
  evt_t  evt;
  logic  emit;

  // Clamp an offset to the 16-bit result field.
  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    if (ext[31:16] != 16'd0) begin
      return 16'hFFFF;
    end
    return ext[15:0];
  endfunction

  assign blank      = (ch_i == ChSpace) || (ch_i == ChTab);
  assign wide_space = blank || ((ch_i >= ChTab) && (ch_i <= ChCr));

  // Phase machine for one byte.
  always_comb begin
    phase_d      = phase_q;
    name_cnt_d   = name_cnt_q;
    value_cnt_d  = value_cnt_q;
    pair_start_d = pair_start_q;
    err          = ErrNone;
    emit         = 1'b0;
    evt          = '0;
    evt.kind     = KindNameChar;
    evt.err      = ErrNone;

    case (phase_q)
      PhSkip: begin
        if (!blank) begin
          pair_start_d = pos_q;
          if (ch_i == ChNul) begin
            emit           = 1'b1;
            evt.kind       = KindEnd;
            evt.name_start = sat16(pos_q);
          end else if (ch_i == ChEq) begin
            err = ErrMissingName;
          end else if (max_name_q == 8'd0) begin
            err = ErrNameLong;
          end else begin
            name_cnt_d     = 8'd1;
            value_cnt_d    = 8'd0;
            phase_d        = PhName;
            emit           = 1'b1;
            evt.kind       = KindNameChar;
            evt.out_char   = ch_i;
            evt.name_start = sat16(pos_q);
          end
        end
      end
      PhName: begin
        if (ch_i == ChEq) begin
          phase_d = PhVFirst;
        end else if (blank) begin
          phase_d = PhBlank;
        end else if (ch_i == ChNul) begin
          err = ErrEqExpected;
        end else if (name_cnt_q >= max_name_q) begin
          err = ErrNameLong;
        end else begin
          name_cnt_d     = name_cnt_q + 8'd1;
          emit           = 1'b1;
          evt.kind       = KindNameChar;
          evt.out_char   = ch_i;
          evt.name_start = sat16(pair_start_q);
        end
      end
      PhBlank: begin
        if (!blank) begin
          err = (ch_i == ChEq) ? ErrBlankBefore : ErrEqExpected;
        end
      end
      PhVFirst: begin
        if (wide_space) begin
          err = ErrSpaceAfter;
        end else if (ch_i == ChNul) begin
          err = ErrEmptyValue;
        end else if (max_value_q == 8'd0) begin
          err = ErrValueLong;
        end else begin
          value_cnt_d    = 8'd1;
          phase_d        = PhValue;
          emit           = 1'b1;
          evt.kind       = KindValueChar;
          evt.out_char   = ch_i;
          evt.name_start = sat16(pair_start_q);
        end
      end
      PhValue: begin
        if (blank || (ch_i == ChNul)) begin
          phase_d        = PhSkip;
          emit           = 1'b1;
          evt.kind       = KindPairDone;
          evt.name_start = sat16(pair_start_q);
          evt.name_len   = name_cnt_q;
          evt.value_len  = value_cnt_q;
          evt.dbl        = (ch_i == ChNul);
          evt.end_start  = sat16(pos_q);
        end else if (value_cnt_q >= max_value_q) begin
          err = ErrValueLong;
        end else begin
          value_cnt_d    = value_cnt_q + 8'd1;
          emit           = 1'b1;
          evt.kind       = KindValueChar;
          evt.out_char   = ch_i;
          evt.name_start = sat16(pair_start_q);
        end
      end
      PhIgnore: begin
        phase_d = PhIgnore;
      end
      default: begin
        phase_d = PhSkip;
      end
    endcase

    // Errors replace any other result and start PhIgnore on nonzero bytes.
    if (err != ErrNone) begin
      emit           = 1'b1;
      evt            = '0;
      evt.kind       = KindError;
      evt.err        = err;
      evt.name_start = sat16(pair_start_d);
      phase_d        = PhIgnore;
    end

    // The ending byte restarts the parser; else pos_q counts up, saturating.
    if (ch_i == ChNul) begin
      phase_d      = PhSkip;
      name_cnt_d   = 8'd0;
      value_cnt_d  = 8'd0;
      pos_d        = '0;
      pair_start_d = '0;
    end else if (pos_q != {OFFSET_BITS{1'b1}}) begin
      pos_d = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    end else begin
      pos_d = pos_q;
    end
  end

  assign evt_o      = evt;
  assign evt_push_o = accept_i && emit;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSkip;
      name_cnt_q   <= 8'd0;
      value_cnt_q  <= 8'd0;
      pos_q        <= '0;
      pair_start_q <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      name_cnt_q   <= name_cnt_d;
      value_cnt_q  <= value_cnt_d;
      pos_q        <= pos_d;
      pair_start_q <= pair_start_d;
    end
  end

  // Length limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_name_q  <= MaxNameReset;
      max_value_q <= MaxValueReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMaxName:  max_name_q  <= cfg_data_i;
        RegMaxValue: max_value_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/nvop_queue.sv
// Short event queue between the parser and the result stage.
`default_nettype none

module nvop_queue import nvop_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  evt_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output evt_t      data_o,
  output logic      empty_o
);

  localparam int unsigned IdxW = $clog2(QueueDepth);

  evt_t            mem_q [QueueDepth];
  logic [IdxW-1:0] wptr_q, rptr_q;
  logic [IdxW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (IdxW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + {{(IdxW-1){1'b0}}, 1'b1};
      end
      if (do_pop) begin
        rptr_q <= rptr_q + {{(IdxW-1){1'b0}}, 1'b1};
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + {{IdxW{1'b0}}, 1'b1};
        2'b01:   cnt_q <= cnt_q - {{IdxW{1'b0}}, 1'b1};
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/nvop_back.sv
// Result stage: turns queued events into result items, one per transfer.
`default_nettype none

module nvop_back import nvop_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  evt_t      evt_i,
  input  wire logic evt_empty_i,
  output logic      evt_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_char_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] name_start_o,
  output logic [7:0]  name_len_o,
  output logic [7:0]  value_len_o,
  output logic        last_o
);

  // Set while the end result of a double event is shown.
  logic second_q;
  logic take;

  assign empty_o = evt_empty_i;
  assign take    = pop_i && !evt_empty_i;

  // Select the shown result.
  always_comb begin
    if (second_q) begin
      kind_o       = KindEnd;
      out_char_o   = 8'd0;
      error_code_o = ErrNone;
      name_start_o = evt_i.end_start;
      name_len_o   = 8'd0;
      value_len_o  = 8'd0;
      last_o       = 1'b1;
    end else begin
      kind_o       = evt_i.kind;
      out_char_o   = evt_i.out_char;
      error_code_o = evt_i.err;
      name_start_o = evt_i.name_start;
      name_len_o   = evt_i.name_len;
      value_len_o  = evt_i.value_len;
      last_o       = !evt_i.dbl;
    end
  end

  // An event leaves the queue after its final result is transferred.
  assign evt_pop_o = take && (second_q || !evt_i.dbl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (take) begin
      second_q <= evt_i.dbl && !second_q;
    end
  end

endmodule

`default_nettype wire

### sv/name_value_option_parser_top.sv
// Top level of the streaming name=value option parser.
//
// Input: one byte of option text per transfer on ch_i, taken when push is
// high and full is low; a zero byte ends the text. Results come out as a
// queue: while empty is low the oldest result is on the result ports, and it
// is transferred when pop is high. Each byte gives zero, one or two results;
// last_o marks the final one for that byte.
// The event of a taken byte is registered in the event queue. Bytes are
// taken one per cycle while full is low; results are transferred one per
// cycle while pop is high; a zero byte closing a value gives two results.
// A four-entry event queue separates parser and result stage; full rises
// when it holds four events and the receiver stalls, and bytes that give
// no result are still taken then only if the queue has room.
// Configuration: cfg_valid_i writes cfg_data_i into register cfg_index_i
// (0 longest name, 1 longest value); cfg_ready_o is always high.
// Reset clears the parser state and the queue and restores the limits
// to 31 and 63.
`default_nettype none

module name_value_option_parser_top import nvop_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         ch_i,
  input  wire logic               pop,
  output logic                    empty,
  output logic [2:0]              kind_o,
  output logic [7:0]              out_char_o,
  output logic [2:0]              error_code_o,
  output logic [15:0]             name_start_o,
  output logic [7:0]              name_len_o,
  output logic [7:0]              value_len_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);

  logic accept;
  evt_t front_evt, head_evt;
  logic front_push, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Parser front end.
  nvop_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (ch_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .evt_o      (front_evt),
    .evt_push_o (front_push)
  );

  // Event queue.
  nvop_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_evt),
    .full_o (full),
    .pop_i  (q_pop),
    .data_o (head_evt),
    .empty_o(q_empty)
  );

  // Result stage.
  nvop_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (head_evt),
    .evt_empty_i (q_empty),
    .evt_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .error_code_o(error_code_o),
    .name_start_o(name_start_o),
    .name_len_o  (name_len_o),
    .value_len_o (value_len_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

### sv/nvop_checker.sv
// Port-level assertions for the option parser and their bind statement.
`default_nettype none

module nvop_checker import nvop_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               pop,
  input wire logic               empty,
  input wire logic [2:0]         kind_o,
  input wire logic [2:0]         error_code_o,
  input wire logic [15:0]        name_start_o,
  input wire logic               last_o
);

  // A waiting result holds until it is transferred.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(name_start_o)
      && $stable(last_o)))
    else $error("result changed while stalled");

  // Error code is set exactly on error results.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((kind_o == KindError) == (error_code_o != ErrNone)))
    else $error("error code does not match kind");

  // End and error results always close their byte.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ((kind_o == KindEnd) || (kind_o == KindError))) |-> last_o)
    else $error("end or error result not marked last");

  // A pair-complete result that is not last is followed by an end result.
  a_pair_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && (kind_o == KindPairDone) && !last_o)
      |=> (!empty && (kind_o == KindEnd)))
    else $error("pair complete not followed by end");

endmodule

bind name_value_option_parser_top nvop_checker u_nvop_checker (.*);

`default_nettype wire
